// File: hdl/grh_pkg.sv
// grh_pkg: request and result types, codes and fixed widths of the gated ratio histogrammer
// no dependencies; imported by every module of the block
package grh_pkg;

    typedef struct packed {
        logic               op;
        logic [5:0]         channel;
        logic [3:0]         fit_type;
        logic [23:0]        chisq;
        logic [9:0]         ndf;
        logic signed [19:0] fast_amp;
        logic signed [19:0] slow_amp;
        logic [14:0]        read_bin;
    } cmd_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  reject_code;
        logic [14:0] bin;
        logic [31:0] count;
    } result_t;

    // control between sequencer and histogram store
    typedef struct packed {
        logic valid;
        logic incr;
    } store_req_t;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] REJ_OK   = 2'd0;
    localparam logic [1:0] REJ_TYPE = 2'd1;
    localparam logic [1:0] REJ_CHI  = 2'd2;
    localparam logic [1:0] REJ_BAD  = 2'd3;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHI_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHI_HIGH  = 2'd3;
    localparam int CFG_DATA_W = 24;

    localparam logic [3:0]  TYPE_LOW_RST  = 4'd0;
    localparam logic [3:0]  TYPE_HIGH_RST = 4'd15;
    localparam logic [23:0] CHI_LOW_RST   = 24'd0;
    localparam logic [23:0] CHI_HIGH_RST  = 24'hFFFFFF;

    // ratio scale and divider widths: 100 * (2^19 - 1) fits in 26 bits
    localparam int RATIO_SCALE = 100;
    localparam int NUM_W       = 26;
    localparam int DEN_W       = 19;
    localparam int PROD_W      = 34;
    localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

endpackage

// File: hdl/grh_divider.sv
// grh_divider: restoring shift-subtract divider, one quotient bit per cycle
// depends on grh_pkg for the operand widths
module grh_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [grh_pkg::NUM_W-1:0] num,
    input  logic [grh_pkg::DEN_W-1:0] den,
    output logic                     done,
    output logic [grh_pkg::NUM_W-1:0] quo,
    output logic [grh_pkg::DEN_W-1:0] rem
);
    import grh_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;

    // one shared subtractor: partial remainder minus divisor
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial[DEN_W+1])
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// File: hdl/grh_hist_store.sv
// grh_hist_store: histogram memory with clearing sweep after reset and saturating increment
// depends on grh_pkg for the request struct and count limit
module grh_hist_store #(
    parameter int ADDR_W = 21,
    parameter int DEPTH  = 2097152
) (
    input  logic                clk,
    input  logic                rst_n,
    input  grh_pkg::store_req_t req,
    input  logic [ADDR_W-1:0]   req_addr,
    output logic                clr_busy,
    output logic                rsp_valid,
    output logic [31:0]         rsp_count
);
    import grh_pkg::*;

    logic [31:0]       mem [DEPTH];
    logic [31:0]       rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              clr_active_reg, clr_active_next;
    store_req_t        pend_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [31:0]       sat_inc;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;

    assign sat_inc = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 32'd1;

    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // write back in the cycle after the read of the same entry
    assign wr_en   = clr_active_reg || (pend_reg.valid && pend_reg.incr);
    assign wr_addr = clr_active_reg ? clr_addr_reg : pend_addr_reg;
    assign wr_data = clr_active_reg ? 32'd0 : sat_inc;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg   <= mem[req_addr];
        pend_addr_reg <= req_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            clr_active_reg <= 1'b1;
            pend_reg       <= '0;
        end
        else
        begin
            clr_addr_reg   <= clr_addr_next;
            clr_active_reg <= clr_active_next;
            pend_reg       <= req;
        end
    end

    assign clr_busy  = clr_active_reg;
    assign rsp_valid = pend_reg.valid;
    assign rsp_count = pend_reg.incr ? sat_inc : rd_data_reg;

endmodule

// File: hdl/gated_ratio_histogrammer_unit.sv
// gated_ratio_histogrammer_unit: top level, request sequencer, gating and ratio rounding
// depends on grh_pkg, grh_divider and grh_hist_store
//
// A request is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle with done high, and the receiver must take it then. After reset
// the histogram store is swept to zero one entry a cycle, CHANNELS * 2^ceil(log2(BINS))
// entries (2097152 with the defaults), with busy high; configuration writes are taken
// throughout. A read passes S_WAIT before done; a rejection for channel, bin, ndf,
// amplitude or type comes from S_IDLE, a chi rejection after S_CHI_LO, S_CHI_HI and
// S_CHI_CHK; an accumulate then passes S_MEM and S_WAIT, after S_DIV and S_ROUND if the
// slow amplitude is positive: the rounded ratio comes from a restoring divider yielding
// one of its 26 quotient bits per cycle, and one multiplier tests both chi limits in turn.
// The next request may be presented in the cycle that done is high.
module gated_ratio_histogrammer_unit #(
    parameter int CHANNELS = 64,
    parameter int BINS     = 32768
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  grh_pkg::cmd_t                     cmd,
    output logic                              done,
    output grh_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [grh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [grh_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import grh_pkg::*;

    localparam int CH_W   = $clog2(CHANNELS);
    localparam int BIN_W  = $clog2(BINS);
    localparam int ADDR_W = CH_W + BIN_W;
    localparam int DEPTH  = CHANNELS * (2 ** BIN_W);
    localparam int BIN_MAX = BINS - 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHI_LO,
        S_CHI_HI,
        S_CHI_CHK,
        S_DIV,
        S_ROUND,
        S_MEM,
        S_WAIT
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    result_t           result_reg, result_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              lo_fail_reg, lo_fail_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [3:0]        type_low_reg, type_low_next;
    logic [3:0]        type_high_reg, type_high_next;
    logic [23:0]       chi_low_reg, chi_low_next;
    logic [23:0]       chi_high_reg, chi_high_next;

    logic              accept;
    logic              clr_busy;
    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  div_num;
    logic [NUM_W-1:0]  div_quo;
    logic [DEN_W-1:0]  div_rem;
    logic [23:0]       mul_op;
    logic [PROD_W-1:0] mul_out;
    store_req_t        st_req;
    logic [ADDR_W-1:0] st_addr;
    logic              st_rsp_valid;
    logic [31:0]       st_rsp_count;
    logic              in_bad;
    logic              in_type_bad;
    logic              rd_bad;
    logic              chi_fail;
    logic [DEN_W:0]    two_rem;
    logic              round_up;
    logic [NUM_W:0]    q_rnd;

    assign busy      = (state_reg != S_IDLE) || clr_busy;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // checks on the incoming request, cheap enough to do at acceptance
    assign in_bad = (cmd.channel == 6'd0) || (32'(cmd.channel) >= CHANNELS)
                    || (cmd.ndf == 10'd0) || (cmd.fast_amp <= 20'sd0);
    assign in_type_bad = (cmd.fit_type < type_low_reg) || (cmd.fit_type > type_high_reg);
    assign rd_bad = (32'(cmd.channel) >= CHANNELS) || (32'(cmd.read_bin) >= BINS);

    // one multiplier serves both chi limits
    assign mul_op  = (state_reg == S_CHI_LO) ? chi_low_reg : chi_high_reg;
    assign mul_out = PROD_W'(mul_op) * PROD_W'(cmd_reg.ndf);
    assign chi_fail = lo_fail_reg || (PROD_W'(cmd_reg.chisq) > prod_reg);

    assign div_num = NUM_W'(cmd_reg.slow_amp[DEN_W-1:0]) * NUM_W'(RATIO_SCALE);

    // round half to even, then clamp to the top usable bin
    assign two_rem  = {div_rem, 1'b0};
    assign round_up = (two_rem > {1'b0, cmd_reg.fast_amp[DEN_W-1:0]})
                      || ((two_rem == {1'b0, cmd_reg.fast_amp[DEN_W-1:0]}) && div_quo[0]);
    assign q_rnd    = {1'b0, div_quo} + (NUM_W + 1)'(round_up);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        result_next    = result_reg;
        done_next      = 1'b0;
        prod_next      = prod_reg;
        lo_fail_next   = lo_fail_reg;
        bin_next       = bin_reg;
        type_low_next  = type_low_reg;
        type_high_next = type_high_reg;
        chi_low_next   = chi_low_reg;
        chi_high_next  = chi_high_reg;
        div_start      = 1'b0;
        st_req         = '0;
        st_addr        = {cmd_reg.channel[CH_W-1:0], bin_reg};

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TYPE_LOW:  type_low_next  = cfg_data[3:0];
                CFG_TYPE_HIGH: type_high_next = cfg_data[3:0];
                CFG_CHI_LOW:   chi_low_next   = cfg_data;
                CFG_CHI_HIGH:  chi_high_next  = cfg_data;
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd;
                    result_next = '0;
                    if (cmd.op == OP_READ)
                    begin
                        result_next.bin = cmd.read_bin;
                        if (rd_bad)
                        begin
                            result_next.reject_code = REJ_BAD;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            st_req.valid = 1'b1;
                            st_addr      = {cmd.channel[CH_W-1:0], BIN_W'(cmd.read_bin)};
                            state_next   = S_WAIT;
                        end
                    end
                    else if (in_bad)
                    begin
                        result_next.reject_code = REJ_BAD;
                        done_next = 1'b1;
                    end
                    else if (in_type_bad)
                    begin
                        result_next.reject_code = REJ_TYPE;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHI_LO;
                    end
                end
            end
            S_CHI_LO:
            begin
                prod_next  = mul_out;
                state_next = S_CHI_HI;
            end
            S_CHI_HI:
            begin
                lo_fail_next = PROD_W'(cmd_reg.chisq) < prod_reg;
                prod_next    = mul_out;
                state_next   = S_CHI_CHK;
            end
            S_CHI_CHK:
            begin
                if (chi_fail)
                begin
                    result_next.reject_code = REJ_CHI;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cmd_reg.slow_amp <= 20'sd0)
                begin
                    bin_next   = '0;
                    state_next = S_MEM;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (q_rnd > (NUM_W + 1)'(BIN_MAX))
                begin
                    bin_next = BIN_W'(BIN_MAX);
                end
                else
                begin
                    bin_next = q_rnd[BIN_W-1:0];
                end
                state_next = S_MEM;
            end
            S_MEM:
            begin
                st_req.valid = 1'b1;
                st_req.incr  = 1'b1;
                result_next.bin = 15'(bin_reg);
                state_next   = S_WAIT;
            end
            S_WAIT:
            begin
                if (st_rsp_valid)
                begin
                    result_next.count    = st_rsp_count;
                    result_next.accepted = (cmd_reg.op == OP_ACCUM);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            result_reg    <= '0;
            done_reg      <= 1'b0;
            prod_reg      <= '0;
            lo_fail_reg   <= 1'b0;
            bin_reg       <= '0;
            type_low_reg  <= TYPE_LOW_RST;
            type_high_reg <= TYPE_HIGH_RST;
            chi_low_reg   <= CHI_LOW_RST;
            chi_high_reg  <= CHI_HIGH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            result_reg    <= result_next;
            done_reg      <= done_next;
            prod_reg      <= prod_next;
            lo_fail_reg   <= lo_fail_next;
            bin_reg       <= bin_next;
            type_low_reg  <= type_low_next;
            type_high_reg <= type_high_next;
            chi_low_reg   <= chi_low_next;
            chi_high_reg  <= chi_high_next;
        end
    end

    grh_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cmd_reg.fast_amp[DEN_W-1:0]),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    grh_hist_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (st_req),
        .req_addr  (st_addr),
        .clr_busy  (clr_busy),
        .rsp_valid (st_rsp_valid),
        .rsp_count (st_rsp_count)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hdl/grh_checker.sv
// grh_checker: port-level assertions for the gated ratio histogrammer, bound to the top level
// depends on grh_pkg for the result type and reject codes
module grh_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             done,
    input  grh_pkg::result_t result
);
    import grh_pkg::*;

    // a result is only shown once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while block busy");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request accepted but block neither busy nor done");

    a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.accepted) |-> (result.reject_code == REJ_OK && result.count != 32'd0))
        else $error("accepted result with reject code or zero count");

    a_reject_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.reject_code != REJ_OK) |-> (!result.accepted && result.count == 32'd0))
        else $error("rejected request reports a count");

endmodule

bind gated_ratio_histogrammer_unit grh_checker u_grh_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
